// ===== hdl/brle_pkg.sv =====
`default_nettype none
package brle_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned WORD_BYTES = 8;
  localparam int unsigned WORD_W = BYTE_W * WORD_BYTES;
  localparam int unsigned FILL_W = 4;

  localparam logic [BYTE_W-1:0] KEY_LITERAL = 8'h80;
  localparam int unsigned LIT_MAX = 127;
  localparam int unsigned FLUSH_MARK = 120;

  typedef logic unit_kind_t;
  localparam unit_kind_t KIND_LIT = 1'b0;
  localparam unit_kind_t KIND_RUN = 1'b1;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [FILL_W-1:0] fill_t;

endpackage
`default_nettype wire

// ===== hdl/brle_in_if.sv =====
`default_nettype none
interface brle_in_if;
  logic               valid;
  logic               ready;
  brle_pkg::byte_t    data_byte;
  logic               block_end;

  modport source(output valid, output data_byte, output block_end, input ready);
  modport sink(input valid, input data_byte, input block_end, output ready);
endinterface
`default_nettype wire

// ===== hdl/brle_out_if.sv =====
`default_nettype none
interface brle_out_if;
  logic               valid;
  logic               ready;
  brle_pkg::word_t    out_word;
  brle_pkg::fill_t    byte_count;
  logic               final_word;

  modport source(output valid, output out_word, output byte_count, output final_word,
                 input ready);
  modport sink(input valid, input out_word, input byte_count, input final_word,
               output ready);
endinterface
`default_nettype wire

// ===== hdl/byte_run_length_encoder.sv =====
`default_nettype none
// byte run-length encoder with packbits-style key bytes
// in_ch carries one raw byte per word; block_end marks the last byte of a block.
// out_ch carries up to eight encoded bytes per word, first byte in bits 7:0,
// byte_count valid bytes, final_word set on the last word of a block.
// a run of three or more equal bytes becomes key=length then the byte; other
// stretches become key=0x80|length then the raw bytes.
// pending bytes sit in a circular buffer in one ram; run/literal tracking is
// done incrementally as each byte arrives, so a unit is closed the moment the
// byte that fixes it is taken.
// a byte that closes no unit passes accept and step end; no new byte is taken
// before its step end. each encoded byte takes a packer step, one byte per
// cycle unless a full word waits on out_ch, and literal bytes come back over
// the single ram read port. a full word moves to the output register when
// the next byte needs the packer or at the step end, and is valid from the
// following cycle. reset clears counters, pointers, packer and the output
// valid flag; ram contents stay undefined and are used only for pending bytes.
// when out_ch stalls the output register holds its word; the packer keeps
// filling until a ninth byte or a step end needs the register, then waits.
module byte_run_length_encoder #(
  parameter int unsigned MAX_RUN      = 127,
  parameter int unsigned BUFFER_DEPTH = 256
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  brle_in_if.sink    in_ch,
  brle_out_if.source out_ch
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned SW = AW + 2;
  localparam logic [CW-1:0] MR      = CW'(MAX_RUN);
  localparam logic [CW-1:0] LMAX    = CW'(brle_pkg::LIT_MAX);
  localparam logic [CW-1:0] LMAX1   = CW'(brle_pkg::LIT_MAX + 1);
  localparam logic [CW-1:0] LMAX2   = CW'(brle_pkg::LIT_MAX + 2);
  localparam logic [CW-1:0] FMARK   = CW'(brle_pkg::FLUSH_MARK);
  localparam logic [CW-1:0] THREE   = CW'(3);
  localparam logic [CW-1:0] FIVE    = CW'(5);
  localparam logic [CW-1:0] TWO     = CW'(2);
  localparam bit            RUN3    = (MAX_RUN == 3);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_KEY  = 2'd1;
  localparam logic [1:0] S_BODY = 2'd2;
  localparam logic [1:0] S_END  = 2'd3;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] p, input logic [CW-1:0] l);
    logic [SW-1:0] s;
    s = SW'(p) + SW'(l);
    if (s >= SW'(BUFFER_DEPTH)) begin
      s = s - SW'(BUFFER_DEPTH);
    end
    return AW'(s);
  endfunction

  // control state
  logic [1:0]       state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [AW-1:0]    head_r, head_nxt;
  logic [AW-1:0]    tail_r, tail_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic             is_run_r, is_run_nxt;
  brle_pkg::byte_t  last_r;
  logic [1:0]       tail_len_r;
  logic             fin_r;
  brle_pkg::byte_t  run_value_r;
  logic [1:0]       nunits_r;
  logic             unit_idx_r, unit_idx_nxt;
  brle_pkg::unit_kind_t u_kind_r [2];
  brle_pkg::byte_t      u_len_r  [2];
  brle_pkg::byte_t  rem_r, rem_nxt;

  // packer and output register
  brle_pkg::word_t  pack_r;
  brle_pkg::fill_t  fill_r;
  logic             out_valid_r;
  brle_pkg::word_t  out_word_r;
  brle_pkg::fill_t  out_count_r;
  logic             out_final_r;

  logic             in_acc;
  logic             out_free;
  logic             can_put;
  logic             put_en;
  brle_pkg::byte_t  put_byte;
  logic             push_end;

  // ram
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  brle_pkg::byte_t  ram_rdata;
  logic [AW-1:0]    rd_inc;
  logic [AW-1:0]    tail_inc;

  // step planning
  logic [CW-1:0]    n;
  logic             byte_eq;
  logic [1:0]       tl_new;
  logic             tail3;
  logic [CW-1:0]    plan_cnt, plan_used;
  logic             plan_run;
  logic [1:0]       plan_units;
  brle_pkg::unit_kind_t pk0, pk1;
  brle_pkg::byte_t      pl0, pl1;

  brle_pkg::unit_kind_t cur_kind;
  brle_pkg::byte_t      cur_len;
  logic                 last_unit;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ch.ready;
  assign can_put  = (fill_r != brle_pkg::fill_t'(brle_pkg::WORD_BYTES)) || out_free;
  assign rd_inc   = (rd_ptr_r == AW'(BUFFER_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
  assign tail_inc = (tail_r == AW'(BUFFER_DEPTH - 1)) ? '0 : tail_r + 1'b1;

  brle_ram #(
    .WIDTH(brle_pkg::BYTE_W),
    .DEPTH(BUFFER_DEPTH)
  ) u_pending (
    .clk   (clk),
    .we    (in_acc),
    .waddr (tail_r),
    .wdata (in_ch.data_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // decide which units the arriving byte closes
  always_comb begin
    n       = cnt_r + 1'b1;
    byte_eq = (cnt_r != '0) && (in_ch.data_byte == last_r);
    tl_new  = byte_eq ? ((tail_len_r == 2'd3) ? 2'd3 : tail_len_r + 1'b1) : 2'd1;
    tail3   = (tl_new == 2'd3);
    plan_cnt   = n;
    plan_used  = '0;
    plan_run   = is_run_r;
    plan_units = 2'd0;
    pk0 = brle_pkg::KIND_LIT;
    pk1 = brle_pkg::KIND_LIT;
    pl0 = '0;
    pl1 = '0;
    if (!in_ch.block_end) begin
      if (is_run_r) begin
        if (byte_eq) begin
          if (n >= MR) begin
            plan_units = 2'd1; pk0 = brle_pkg::KIND_RUN; pl0 = 8'(MR);
            plan_used = MR; plan_cnt = '0; plan_run = 1'b0;
          end
        end else begin
          plan_units = 2'd1; pk0 = brle_pkg::KIND_RUN; pl0 = 8'(cnt_r);
          plan_used = cnt_r; plan_cnt = CW'(1); plan_run = 1'b0;
        end
      end else if (n == THREE && tail3) begin
        if (RUN3) begin
          plan_units = 2'd1; pk0 = brle_pkg::KIND_RUN; pl0 = 8'd3;
          plan_used = THREE; plan_cnt = '0;
        end else begin
          plan_run = 1'b1;
        end
      end else if (n >= FIVE && tail3) begin
        // literal up to the first triple, kept as run head if MAX_RUN > 3
        plan_units = 2'd1; pk0 = brle_pkg::KIND_LIT; pl0 = 8'(n - THREE);
        plan_used = n - THREE; plan_cnt = THREE; plan_run = 1'b1;
        if (RUN3) begin
          plan_units = 2'd2; pk1 = brle_pkg::KIND_RUN; pl1 = 8'd3;
          plan_used = n; plan_cnt = '0; plan_run = 1'b0;
        end
      end else if (n == LMAX1 && !byte_eq) begin
        // capped literal is fixed once its last byte differs from the next
        plan_units = 2'd1; pk0 = brle_pkg::KIND_LIT; pl0 = 8'(LMAX);
        plan_used = LMAX; plan_cnt = CW'(1);
      end else if (n == LMAX2) begin
        plan_units = 2'd1; pk0 = brle_pkg::KIND_LIT; pl0 = 8'(LMAX);
        plan_used = LMAX; plan_cnt = TWO;
      end
    end else begin
      plan_cnt = '0;
      plan_run = 1'b0;
      if (is_run_r) begin
        pk0 = brle_pkg::KIND_RUN;
        if (byte_eq) begin
          plan_units = 2'd1; pl0 = 8'(n);
        end else begin
          plan_units = 2'd2; pl0 = 8'(cnt_r);
          pk1 = brle_pkg::KIND_LIT; pl1 = 8'd1;
        end
      end else if (n <= TWO) begin
        plan_units = 2'd1; pk0 = brle_pkg::KIND_LIT; pl0 = 8'(n);
      end else if (n == THREE && tail3) begin
        plan_units = 2'd1; pk0 = brle_pkg::KIND_RUN; pl0 = 8'd3;
      end else if (n >= FIVE && tail3) begin
        plan_units = 2'd2; pk0 = brle_pkg::KIND_LIT; pl0 = 8'(n - THREE);
        pk1 = brle_pkg::KIND_RUN; pl1 = 8'd3;
      end else if (n > LMAX) begin
        // block tail beyond the literal cap
        plan_units = 2'd2; pk0 = brle_pkg::KIND_LIT; pl0 = 8'(LMAX);
        pk1 = brle_pkg::KIND_LIT; pl1 = 8'(n - LMAX);
      end else begin
        plan_units = 2'd1; pk0 = brle_pkg::KIND_LIT; pl0 = 8'(n);
      end
    end
  end

  assign cur_kind  = u_kind_r[unit_idx_r];
  assign cur_len   = u_len_r[unit_idx_r];
  assign last_unit = (nunits_r == 2'd1) || unit_idx_r;

  // sequencer: key byte, then body bytes, then step-end word flush
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    rd_ptr_nxt   = rd_ptr_r;
    is_run_nxt   = is_run_r;
    unit_idx_nxt = unit_idx_r;
    rem_nxt      = rem_r;
    put_en       = 1'b0;
    put_byte     = '0;
    push_end     = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = rd_ptr_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          tail_nxt     = tail_inc;
          cnt_nxt      = plan_cnt;
          is_run_nxt   = plan_run;
          rd_ptr_nxt   = head_r;
          unit_idx_nxt = 1'b0;
          head_nxt     = in_ch.block_end ? tail_inc : wrap_add(head_r, plan_used);
          state_nxt    = (plan_units != 2'd0) ? S_KEY : S_END;
        end
      end
      S_KEY: begin
        ram_re    = 1'b1;
        ram_raddr = rd_ptr_r;
        put_byte  = (cur_kind == brle_pkg::KIND_RUN) ? cur_len
                                                     : (brle_pkg::KEY_LITERAL | cur_len);
        if (can_put) begin
          put_en = 1'b1;
          if (cur_kind == brle_pkg::KIND_RUN) begin
            rd_ptr_nxt = wrap_add(rd_ptr_r, CW'(cur_len));
            rem_nxt    = 8'd1;
          end else begin
            rem_nxt    = cur_len;
          end
          state_nxt = S_BODY;
        end
      end
      S_BODY: begin
        ram_raddr = rd_inc;
        put_byte  = (cur_kind == brle_pkg::KIND_RUN) ? run_value_r : ram_rdata;
        if (can_put) begin
          put_en  = 1'b1;
          rem_nxt = rem_r - 1'b1;
          if (cur_kind == brle_pkg::KIND_LIT) begin
            ram_re     = 1'b1;
            rd_ptr_nxt = rd_inc;
          end
          if (rem_r == 8'd1) begin
            if (last_unit) begin
              state_nxt = S_END;
            end else begin
              unit_idx_nxt = 1'b1;
              state_nxt    = S_KEY;
            end
          end
        end
      end
      S_END: begin
        if (fin_r ? (fill_r != '0)
                  : ((fill_r == brle_pkg::fill_t'(brle_pkg::WORD_BYTES)) ||
                     ((cnt_r >= FMARK) && (fill_r != '0)))) begin
          if (out_free) begin
            push_end  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      rd_ptr_r    <= '0;
      is_run_r    <= 1'b0;
      tail_len_r  <= 2'd0;
      unit_idx_r  <= 1'b0;
      nunits_r    <= 2'd0;
      fin_r       <= 1'b0;
      fill_r      <= '0;
      pack_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      rd_ptr_r   <= rd_ptr_nxt;
      is_run_r   <= is_run_nxt;
      unit_idx_r <= unit_idx_nxt;
      if (in_acc) begin
        tail_len_r <= tl_new;
        nunits_r   <= plan_units;
        fin_r      <= in_ch.block_end;
      end
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (put_en) begin
        if (fill_r == brle_pkg::fill_t'(brle_pkg::WORD_BYTES)) begin
          // ninth byte: hand the full word over first
          out_valid_r <= 1'b1;
          pack_r      <= brle_pkg::word_t'(put_byte);
          fill_r      <= brle_pkg::fill_t'(1);
        end else begin
          pack_r[fill_r[2:0]*brle_pkg::BYTE_W +: brle_pkg::BYTE_W] <= put_byte;
          fill_r <= fill_r + 1'b1;
        end
      end
      if (push_end) begin
        out_valid_r <= 1'b1;
        pack_r      <= '0;
        fill_r      <= '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    if (in_acc) begin
      last_r      <= in_ch.data_byte;
      run_value_r <= is_run_r ? last_r : in_ch.data_byte;
      u_kind_r[0] <= pk0;
      u_kind_r[1] <= pk1;
      u_len_r[0]  <= pl0;
      u_len_r[1]  <= pl1;
    end
    if ((put_en && (fill_r == brle_pkg::fill_t'(brle_pkg::WORD_BYTES))) || push_end) begin
      out_word_r  <= pack_r;
      out_count_r <= fill_r;
      out_final_r <= push_end && fin_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_word   = out_word_r;
  assign out_ch.byte_count = out_count_r;
  assign out_ch.final_word = out_final_r;

  // pending bytes never pile up beyond a capped literal plus two
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LMAX2)
    else $error("pending count out of range");

  // a run head always holds at least the three bytes that formed it
  a_run_head: assert property (@(posedge clk) disable iff (!rst_n)
    is_run_r |-> (cnt_r >= THREE))
    else $error("run head with too few bytes");

  // a block end empties the buffer
  a_fin_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.block_end) |=> (cnt_r == '0) && (head_r == tail_r))
    else $error("pending bytes left after block end");

  // the packer never holds more than one word
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= brle_pkg::fill_t'(brle_pkg::WORD_BYTES))
    else $error("packer overfilled");

  // a word is never overwritten while the receiver stalls
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> out_valid_r && $stable(out_word_r))
    else $error("output word lost");

endmodule
`default_nettype wire

// ===== hdl/brle_ram.sv =====
`default_nettype none
module brle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire
